FILE: hdl/buzz_pkg.sv
// Package for the buzzer pattern generator: pattern codes, op codes and
// timing constants in milliseconds. No dependencies.
package buzz_pkg;

    typedef logic [2:0] pattern_t;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    localparam pattern_t PAT_OFF       = 3'd0;
    localparam pattern_t PAT_BOOT      = 3'd1;
    localparam pattern_t PAT_VERIFY    = 3'd2;
    localparam pattern_t PAT_COUNTDOWN = 3'd3;
    localparam pattern_t PAT_ALERT     = 3'd4;
    localparam pattern_t PAT_CANCEL    = 3'd5;
    localparam pattern_t PAT_ERROR     = 3'd6;
    localparam pattern_t PAT_PAIRING   = 3'd7;

    // countdown thresholds on remaining time
    localparam logic [15:0] CD_LIMIT_200 = 16'd5000;
    localparam logic [15:0] CD_LIMIT_400 = 16'd10000;
    localparam logic [15:0] CD_LIMIT_700 = 16'd20000;

    // phase counter moduli
    localparam logic [10:0] PER_ALERT   = 11'd1200;
    localparam logic [10:0] PER_PAIRING = 11'd2000;
    localparam logic [9:0]  PER_700     = 10'd700;

    // on-time thresholds, one third of each countdown period
    localparam logic [9:0] ON_200  = 10'd66;
    localparam logic [9:0] ON_400  = 10'd133;
    localparam logic [9:0] ON_700  = 10'd233;
    localparam logic [9:0] ON_1000 = 10'd333;

    localparam logic [10:0] ON_ALERT   = 11'd900;
    localparam logic [10:0] ON_PAIRING = 11'd60;

endpackage

FILE: hdl/buzzer_pattern_generator_core.sv
// Buzzer pattern generator core: tick / select beats in, buzzer level and
// active pattern out. Depends on buzz_pkg.
//
// Each accepted input beat gives a registered result beat in the next cycle.
// Throughput: one beat per cycle; the output register takes a new result
// whenever it is empty or being drained in the same cycle.
// Modulo phases come from phase counters kept beside the elapsed count and
// stepped with it, so no divider sits in the path.
// Reset (rst_n low, asynchronous): pattern off, elapsed count and phases
// zero, buzzer silent, no result pending.
module buzzer_pattern_generator_core
    import buzz_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [2:0] pattern, [18:3] countdown_ms, [23:19] zero
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] buzzer_on, [3:1] active_pattern, [7:4] zero
);

    pattern_t    pattern_reg, pattern_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic        level_reg, level_next;
    logic [10:0] ph1200_reg, ph1200_next;
    logic [10:0] ph2000_reg, ph2000_next;
    logic [9:0]  ph700_reg, ph700_next;
    logic        out_valid_reg;
    logic [3:0]  out_data_reg;

    logic        in_accept;
    logic        in_op;
    pattern_t    in_pattern;
    logic [15:0] in_countdown;

    logic [31:0] t_inc;
    logic        t_wrap;
    logic [10:0] p1200, p2000;
    logic [9:0]  p700;
    logic [8:0]  p400, p200;
    logic [9:0]  p1000;
    logic        tick_on, tick_done;

    assign in_op        = s_axis_tuser;
    assign in_pattern   = s_axis_tdata[2:0];
    assign in_countdown = s_axis_tdata[18:3];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // phases of the advanced count; all restart when the count wraps to zero
    always_comb
    begin
        t_inc  = elapsed_reg + 32'd1;
        t_wrap = (t_inc == 32'd0);
        p1200  = (t_wrap || ph1200_reg == PER_ALERT - 11'd1) ? 11'd0 : ph1200_reg + 11'd1;
        p2000  = (t_wrap || ph2000_reg == PER_PAIRING - 11'd1) ? 11'd0 : ph2000_reg + 11'd1;
        p700   = (t_wrap || ph700_reg == PER_700 - 10'd1) ? 10'd0 : ph700_reg + 10'd1;

        if (p1200 >= 11'd800)
            p400 = 9'(p1200 - 11'd800);
        else if (p1200 >= 11'd400)
            p400 = 9'(p1200 - 11'd400);
        else
            p400 = p1200[8:0];
        p200  = (p400 >= 9'd200) ? p400 - 9'd200 : p400;
        p1000 = (p2000 >= 11'd1000) ? 10'(p2000 - 11'd1000) : p2000[9:0];
    end

    always_comb
    begin
        tick_on   = 1'b0;
        tick_done = 1'b0;
        case (pattern_reg)
            PAT_BOOT:
            begin
                tick_on   = (t_inc < 32'd80) || (t_inc >= 32'd180 && t_inc < 32'd260);
                tick_done = t_inc > 32'd400;
            end
            PAT_VERIFY:
            begin
                tick_on   = t_inc < 32'd150;
                tick_done = t_inc > 32'd250;
            end
            PAT_COUNTDOWN:
            begin
                if (in_countdown < CD_LIMIT_200)
                    tick_on = {1'b0, p200} < ON_200;
                else if (in_countdown < CD_LIMIT_400)
                    tick_on = {1'b0, p400} < ON_400;
                else if (in_countdown < CD_LIMIT_700)
                    tick_on = p700 < ON_700;
                else
                    tick_on = p1000 < ON_1000;
            end
            PAT_ALERT:
                tick_on = p1200 < ON_ALERT;
            PAT_CANCEL:
            begin
                tick_on   = t_inc < 32'd600;
                tick_done = t_inc > 32'd700;
            end
            PAT_ERROR:
            begin
                tick_on   = (t_inc < 32'd70) || (t_inc >= 32'd160 && t_inc < 32'd230)
                         || (t_inc >= 32'd320 && t_inc < 32'd390);
                tick_done = t_inc > 32'd500;
            end
            PAT_PAIRING:
                tick_on = p2000 < ON_PAIRING;
            default:
                tick_on = 1'b0;
        endcase
    end

    always_comb
    begin
        pattern_next = pattern_reg;
        elapsed_next = elapsed_reg;
        level_next   = level_reg;
        ph1200_next  = ph1200_reg;
        ph2000_next  = ph2000_reg;
        ph700_next   = ph700_reg;
        if (in_accept)
        begin
            if (in_op == OP_SELECT)
            begin
                if (in_pattern != pattern_reg)
                begin
                    pattern_next = in_pattern;
                    elapsed_next = 32'd0;
                    level_next   = 1'b0;
                    ph1200_next  = 11'd0;
                    ph2000_next  = 11'd0;
                    ph700_next   = 10'd0;
                end
            end
            else if (tick_done)
            begin
                // one-shot finished: back to off, count cleared
                pattern_next = PAT_OFF;
                elapsed_next = 32'd0;
                level_next   = 1'b0;
                ph1200_next  = 11'd0;
                ph2000_next  = 11'd0;
                ph700_next   = 10'd0;
            end
            else
            begin
                elapsed_next = t_inc;
                level_next   = tick_on;
                ph1200_next  = p1200;
                ph2000_next  = p2000;
                ph700_next   = p700;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= PAT_OFF;
            elapsed_reg   <= 32'd0;
            level_reg     <= 1'b0;
            ph1200_reg    <= 11'd0;
            ph2000_reg    <= 11'd0;
            ph700_reg     <= 10'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pattern_reg <= pattern_next;
            elapsed_reg <= elapsed_next;
            level_reg   <= level_next;
            ph1200_reg  <= ph1200_next;
            ph2000_reg  <= ph2000_next;
            ph700_reg   <= ph700_next;
            if (in_accept)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= {pattern_next, level_next};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_data_reg};

endmodule
